>>> rtl/crc8f_pkg.sv
// ----------------------------------------------------------------------------
// crc8f_pkg
// shared types, constants and the bytewise crc-8 update for the frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package crc8f_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = 3;

  localparam logic [ByteW-1:0] CrcPoly   = 8'h07;
  localparam logic [ByteW-1:0] CrcInit   = 8'hFF;
  localparam logic [ByteW-1:0] MinFrame  = 8'd3;
  localparam logic [ByteW-1:0] LenReset  = 8'd4;
  localparam logic [ByteW-1:0] StartReset = 8'd64;

  // register indexes, selected by paddr[2]
  localparam logic RegFrameLength = 1'b0;
  localparam logic RegStartByte   = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] lead_byte;
  } cfg_t;

  // msb first, no reflection, no final xor
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] v;
    v = crc ^ data;
    for (int i = 0; i < ByteW; i++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/crc8_frame_checker.sv
// ----------------------------------------------------------------------------
// crc8_frame_checker
// the verdict for a frame is on out_* in the cycle after its last byte is taken
// throughput: one byte per cycle while in_stall is low, set by the combinational crc-8 xor network
// input stalls only while a verdict sits in the output register under stall
// reset (rst_n low, synchronous): frame state cleared, length 4, start byte 64
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_frame_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // byte input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [crc8f_pkg::ByteW-1:0]   in_data_byte,
  // verdict output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_frame_ok,
  output logic                               out_start_ok,
  output logic      [crc8f_pkg::ByteW-1:0]   out_crc_remainder,
  // configuration
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [crc8f_pkg::AddrW-1:0]   cfg_paddr,
  input  wire logic [crc8f_pkg::DataW-1:0]   cfg_pwdata,
  output logic      [crc8f_pkg::DataW-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  crc8f_pkg::cfg_t cfg;

  // register file
  crc8f_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // frame state
  logic [crc8f_pkg::ByteW-1:0] byte_count_r, byte_count_nxt;
  logic [crc8f_pkg::ByteW-1:0] crc_r, crc_nxt;
  logic                        start_match_r, start_match_nxt;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic                        frame_ok_r, start_ok_r;
  logic [crc8f_pkg::ByteW-1:0] crc_rem_r;

  logic                        accept;
  logic                        out_free;
  logic [crc8f_pkg::ByteW-1:0] eff_len;
  logic [crc8f_pkg::ByteW:0]   received;
  logic                        last_byte;
  logic [crc8f_pkg::ByteW-1:0] crc_upd;
  logic                        match_upd;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !out_free;
  assign accept   = in_valid && !in_stall;

  // lengths below the minimum behave as the minimum
  assign eff_len  = (cfg.frame_length < crc8f_pkg::MinFrame) ? crc8f_pkg::MinFrame
                                                              : cfg.frame_length;
  assign received = {1'b0, byte_count_r} + 9'd1;
  // also ends a frame whose count already passed a shortened length
  assign last_byte = received >= {1'b0, eff_len};

  assign crc_upd   = crc8f_pkg::crc8_byte(crc_r, in_data_byte);
  // both leading bytes compared against the start byte as it stands now
  assign match_upd = start_match_r &&
                     !((byte_count_r < 8'd2) && (in_data_byte != cfg.lead_byte));

  always_comb begin
    byte_count_nxt  = byte_count_r;
    crc_nxt         = crc_r;
    start_match_nxt = start_match_r;
    out_valid_nxt   = out_valid_r && out_stall;
    if (accept) begin
      if (last_byte) begin
        // verdict goes out, frame restarts
        byte_count_nxt  = '0;
        crc_nxt         = crc8f_pkg::CrcInit;
        start_match_nxt = 1'b1;
        out_valid_nxt   = 1'b1;
      end else begin
        byte_count_nxt  = received[crc8f_pkg::ByteW-1:0];
        crc_nxt         = crc_upd;
        start_match_nxt = match_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      crc_r         <= crc8f_pkg::CrcInit;
      start_match_r <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      crc_r         <= crc_nxt;
      start_match_r <= start_match_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // verdict payload, loaded only with a frame's last byte
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      frame_ok_r <= match_upd && (crc_upd == '0);
      start_ok_r <= match_upd;
      crc_rem_r  <= crc_upd;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_ok      = frame_ok_r;
  assign out_start_ok      = start_ok_r;
  assign out_crc_remainder = crc_rem_r;

`ifndef SYNTHESIS
  // a verdict appears only right after a byte was taken
  a_verdict_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && !in_stall))
    else $error("verdict without accepted byte");

  // frame_ok needs matching start bytes and a zero remainder
  a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && frame_ok_r |-> start_ok_r && (crc_rem_r == '0))
    else $error("frame_ok inconsistent with start_ok or remainder");

  // after a verdict the frame state is back at its start values
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> (byte_count_r == '0) && (crc_r == crc8f_pkg::CrcInit)
                            && start_match_r)
    else $error("frame state not restarted after verdict");

  // a non-final byte advances the count by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !last_byte |=> byte_count_r == $past(byte_count_r) + 8'd1)
    else $error("byte count did not advance");
`endif

endmodule

`default_nettype wire

>>> rtl/crc8f_regs.sv
// ----------------------------------------------------------------------------
// crc8f_regs
// apb register file holding frame length and start byte
// ----------------------------------------------------------------------------
`default_nettype none

module crc8f_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crc8f_pkg::AddrW-1:0]   paddr,
  input  wire logic [crc8f_pkg::DataW-1:0]   pwdata,
  output logic      [crc8f_pkg::DataW-1:0]   prdata,
  output logic                               pready,
  output crc8f_pkg::cfg_t                    cfg
);

  crc8f_pkg::cfg_t cfg_r;
  crc8f_pkg::cfg_t cfg_nxt;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        crc8f_pkg::RegFrameLength: cfg_nxt.frame_length = pwdata[crc8f_pkg::ByteW-1:0];
        crc8f_pkg::RegStartByte:   cfg_nxt.lead_byte    = pwdata[crc8f_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length <= crc8f_pkg::LenReset;
      cfg_r.lead_byte    <= crc8f_pkg::StartReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      crc8f_pkg::RegFrameLength: prdata[crc8f_pkg::ByteW-1:0] = cfg_r.frame_length;
      crc8f_pkg::RegStartByte:   prdata[crc8f_pkg::ByteW-1:0] = cfg_r.lead_byte;
      default: prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire
